// File: hw/rtl/lil_pkg.sv
// Shared types, codes and constants of the learned index lookup unit.
`timescale 1ns / 1ps
`default_nettype none
package lil_pkg;

   localparam int WORD_W      = 64;
   localparam int SLOT_W      = 12;
   localparam int SCALE_SHIFT = 20;
   localparam int FRAC_GAP    = 12;   // Q32.32 fraction bits minus the scale shift.
   localparam logic [WORD_W-1:0] INT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] INT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_BUILD  = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_code_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CLEAR,
      DP_WB_SQ,
      DP_WB_APPEND,
      DP_WB_MX,
      DP_WB_MYQ,
      DP_WB_MXY,
      DP_WB_MXX,
      DP_WB_T2,
      DP_DEGEN,
      DP_ZERO_FIT,
      DP_WB_T,
      DP_WB_SLOPE,
      DP_WB_SATMUL,
      DP_WB_ICPT,
      DP_WB_PRED,
      DP_WB_IDX,
      DP_RD_CUR,
      DP_STEP_DN,
      DP_SET_CUR,
      DP_RD_NEXT,
      DP_STEP_UP
   } dp_op_type;

   typedef enum logic [1:0] {
      MA_KEY,
      MA_CNT,
      MA_MX,
      MA_SLOPE
   } mul_a_sel_type;

   typedef enum logic [1:0] {
      MB_KEY,
      MB_MX,
      MB_MYQ
   } mul_b_sel_type;

   typedef enum logic [2:0] {
      DN_SX,
      DN_SY,
      DN_SXY,
      DN_SXX,
      DN_COV
   } div_num_sel_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_APP_SQ_GO,
      ST_APP_SQ_WAIT,
      ST_APP_XY_GO,
      ST_APP_XY_WAIT,
      ST_BLD_MX_GO,
      ST_BLD_MX_WAIT,
      ST_BLD_MYQ_GO,
      ST_BLD_MYQ_WAIT,
      ST_BLD_MXY_GO,
      ST_BLD_MXY_WAIT,
      ST_BLD_MXX_GO,
      ST_BLD_MXX_WAIT,
      ST_BLD_T2_GO,
      ST_BLD_T2_WAIT,
      ST_BLD_CHECK,
      ST_BLD_T_GO,
      ST_BLD_T_WAIT,
      ST_BLD_SLOPE_GO,
      ST_BLD_SLOPE_WAIT,
      ST_BLD_ICPT_GO,
      ST_BLD_ICPT_WAIT,
      ST_BLD_ICPT,
      ST_LK_PRED_GO,
      ST_LK_PRED_WAIT,
      ST_LK_PRED,
      ST_LK_IDX,
      ST_LK_RD,
      ST_LK_DN,
      ST_LK_UPC,
      ST_LK_UP,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic            req_take;
      dp_op_type       op;
      logic            mul_start;
      mul_a_sel_type   mul_a;
      mul_b_sel_type   mul_b;
      logic            div_start;
      div_num_sel_type div_num;
      logic            rsp_load;
      logic            rsp_flag;
      logic            rsp_use_idx;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic         left;
      logic         mul_done;
      logic         div_done;
      logic         table_empty;
      logic         table_full;
      logic         degen;
      logic         rd_lt_key;
      logic         rd_eq_key;
      logic         cur_lt_key;
      logic         cur_eq_key;
      logic         idx_zero;
      logic         idx_last;
   } dp_status_type;

endpackage
`default_nettype wire

// File: hw/rtl/lil_mul.sv
// Unsigned 64 by 64 multiplier built from four 32 by 32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module lil_mul
   import lil_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [WORD_W-1:0]   a,
   input  wire logic [WORD_W-1:0]   b,
   output logic [2*WORD_W-1:0]      prod,
   output logic                     done
);

   localparam int HALF_W = WORD_W / 2;

   logic [WORD_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [1:0]          step_ff, step_in, sh_ff, sh_in;
   logic                busy_ff, busy_in, ppv_ff, ppv_in, done_ff, done_in;
   logic [WORD_W-1:0]   pp_ff, pp_in;
   logic [2*WORD_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]   a_half, b_half;

   always_comb begin
      a_half  = step_ff[1] ? a_ff[WORD_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_half  = step_ff[0] ? b_ff[WORD_W-1:HALF_W] : b_ff[HALF_W-1:0];
      a_in    = a_ff;
      b_in    = b_ff;
      step_in = step_ff;
      sh_in   = sh_ff;
      busy_in = busy_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      ppv_in  = 1'b0;
      done_in = 1'b0;
      if (ppv_ff) begin
         unique case (sh_ff)
            2'd0: acc_in = acc_ff + {{WORD_W{1'b0}}, pp_ff};
            2'd1, 2'd2: acc_in = acc_ff + {{HALF_W{1'b0}}, pp_ff, {HALF_W{1'b0}}};
            2'd3: acc_in = acc_ff + {pp_ff, {WORD_W{1'b0}}};
            default: acc_in = acc_ff;
         endcase
         done_in = (sh_ff == 2'd3);
      end
      if (busy_ff) begin
         pp_in   = {{HALF_W{1'b0}}, a_half} * {{HALF_W{1'b0}}, b_half};
         sh_in   = step_ff;
         ppv_in  = 1'b1;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         step_in = 2'd0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ppv_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ppv_ff  <= ppv_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      step_ff <= step_in;
      sh_ff   <= sh_in;
      pp_ff   <= pp_in;
      acc_ff  <= acc_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// File: hw/rtl/lil_div.sv
// Unsigned 64-bit restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lil_div
   import lil_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] num,
   input  wire logic [WORD_W-1:0] den,
   output logic [WORD_W-1:0]      quot,
   output logic                   done
);

   localparam int CNT_W = $clog2(WORD_W);

   logic [WORD_W-1:0] rem_ff, rem_in, quot_ff, quot_in, den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [WORD_W:0]   rem_sh;
   logic              fits;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[WORD_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in  = fits ? WORD_W'(rem_sh - {1'b0, den_ff}) : rem_sh[WORD_W-1:0];
         quot_in = {quot_ff[WORD_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (start) begin
         rem_in  = '0;
         quot_in = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// File: hw/rtl/lil_datapath.sv
// Datapath: position table, running sums, fit registers, arithmetic units and walk pointer.
`timescale 1ns / 1ps
`default_nettype none
module lil_datapath
   import lil_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int POS_BITS    = 31
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [POS_BITS-1:0] req_position,
   input  wire logic                req_left_mode,
   input  wire ctrl_cmd_type        cmd,
   output dp_status_type            status,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic                     rsp_empty_flag
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   function automatic logic [WORD_W-1:0] sat_mag(input logic neg,
                                                 input logic [2*WORD_W-1:0] p);
      logic [WORD_W-1:0] r;
      if (p[2*WORD_W-1:WORD_W-1] != '0) begin
         r = neg ? INT_MIN : INT_MAX;
      end else begin
         r = neg ? (WORD_W'(0) - p[WORD_W-1:0]) : p[WORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] clamp_sum(input logic [WORD_W:0] s);
      logic [WORD_W-1:0] r;
      if (s[WORD_W] != s[WORD_W-1]) begin
         r = s[WORD_W] ? INT_MIN : INT_MAX;
      end else begin
         r = s[WORD_W-1:0];
      end
      return r;
   endfunction

   logic [POS_BITS-1:0] mem [TABLE_DEPTH];

   cmd_code_type        cmd_ff, cmd_in;
   logic [POS_BITS-1:0] key_ff, key_in, rd_ff, cur_ff, cur_in;
   logic                left_ff, left_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WORD_W-1:0]   sx_ff, sx_in, sxx_ff, sxx_in, sy_ff, sy_in, sxy_ff, sxy_in;
   logic [WORD_W-1:0]   slope_ff, slope_in, icpt_ff, icpt_in;
   logic [WORD_W-1:0]   mx_ff, mx_in, myq_ff, myq_in, mxy_ff, mxy_in, mxx_ff, mxx_in;
   logic [WORD_W-1:0]   var_ff, var_in, cov_ff, cov_in, tmp_ff, tmp_in;
   logic                covneg_ff, covneg_in, degen_ff, degen_in;
   logic [IDX_W-1:0]    idx_ff, idx_in, rd_addr;
   logic                rd_en;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic [WORD_W-1:0]   key64, slope_mag, mul_a, mul_b, div_num, div_den, quot;
   logic [WORD_W-1:0]   t_val, myq32;
   logic [2*WORD_W-1:0] prod;
   logic                mul_done, div_done;
   logic [WORD_W:0]     round_v;
   logic [WORD_W-32:0]  round_hi;

   always_comb begin
      key64     = WORD_W'(key_ff);
      slope_mag = slope_ff[WORD_W-1] ? (WORD_W'(0) - slope_ff) : slope_ff;
      unique case (cmd.mul_a)
         MA_KEY:   mul_a = key64;
         MA_CNT:   mul_a = WORD_W'(count_ff);
         MA_MX:    mul_a = mx_ff;
         MA_SLOPE: mul_a = slope_mag;
         default:  mul_a = key64;
      endcase
      unique case (cmd.mul_b)
         MB_KEY:  mul_b = key64;
         MB_MX:   mul_b = mx_ff;
         MB_MYQ:  mul_b = myq_ff;
         default: mul_b = key64;
      endcase
      unique case (cmd.div_num)
         DN_SX:   div_num = sx_ff;
         DN_SY:   div_num = sy_ff << SCALE_SHIFT;
         DN_SXY:  div_num = sxy_ff;
         DN_SXX:  div_num = sxx_ff;
         DN_COV:  div_num = cov_ff << FRAC_GAP;
         default: div_num = sx_ff;
      endcase
      div_den = (cmd.div_num == DN_COV) ? var_ff : WORD_W'(count_ff);
   end

   lil_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod),
      .done  (mul_done)
   );

   lil_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot),
      .done  (div_done)
   );

   always_comb begin
      t_val    = prod[WORD_W-1:0] >> SCALE_SHIFT;
      myq32    = (myq_ff[WORD_W-1-FRAC_GAP]) ? INT_MAX : (myq_ff << FRAC_GAP);
      // Round half up: add one half in Q32.32, then keep the integer part.
      round_v  = {1'b0, tmp_ff} + (WORD_W+1)'(64'h8000_0000);
      round_hi = round_v[WORD_W:32];

      cmd_in       = cmd_ff;
      key_in       = key_ff;
      left_in      = left_ff;
      count_in     = count_ff;
      sx_in        = sx_ff;
      sxx_in       = sxx_ff;
      sy_in        = sy_ff;
      sxy_in       = sxy_ff;
      slope_in     = slope_ff;
      icpt_in      = icpt_ff;
      mx_in        = mx_ff;
      myq_in       = myq_ff;
      mxy_in       = mxy_ff;
      mxx_in       = mxx_ff;
      var_in       = var_ff;
      cov_in       = cov_ff;
      tmp_in       = tmp_ff;
      covneg_in    = covneg_ff;
      degen_in     = degen_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      rd_addr      = idx_ff;
      rd_en        = 1'b0;
      rsp_slot_in  = rsp_slot_ff;
      rsp_empty_in = rsp_empty_ff;

      if (cmd.req_take) begin
         cmd_in  = cmd_code_type'(req_cmd);
         key_in  = req_position;
         left_in = req_left_mode;
      end

      unique case (cmd.op)
         DP_CLEAR: begin
            count_in = '0;
            sx_in    = '0;
            sxx_in   = '0;
            sy_in    = '0;
            sxy_in   = '0;
            slope_in = '0;
            icpt_in  = '0;
         end
         DP_WB_SQ: sxx_in = sxx_ff + prod[SCALE_SHIFT +: WORD_W];
         DP_WB_APPEND: begin
            sx_in    = sx_ff + key64;
            sy_in    = sy_ff + WORD_W'(count_ff);
            sxy_in   = sxy_ff + prod[WORD_W-1:0];
            count_in = count_ff + CNT_W'(1);
         end
         DP_WB_MX:  mx_in  = quot;
         DP_WB_MYQ: myq_in = quot;
         DP_WB_MXY: mxy_in = quot;
         DP_WB_MXX: mxx_in = quot;
         DP_WB_T2: begin
            degen_in = (mxx_ff <= t_val);
            var_in   = mxx_ff - t_val;
         end
         DP_DEGEN: begin
            slope_in = '0;
            icpt_in  = myq32;
         end
         DP_ZERO_FIT: begin
            slope_in = '0;
            icpt_in  = '0;
         end
         DP_WB_T: begin
            covneg_in = (mxy_ff < t_val);
            cov_in    = (mxy_ff < t_val) ? (t_val - mxy_ff) : (mxy_ff - t_val);
         end
         DP_WB_SLOPE:  slope_in = sat_mag(covneg_ff, {{WORD_W{1'b0}}, quot});
         DP_WB_SATMUL: tmp_in = sat_mag(slope_ff[WORD_W-1], prod);
         DP_WB_ICPT:
            icpt_in = clamp_sum({myq32[WORD_W-1], myq32} - {tmp_ff[WORD_W-1], tmp_ff});
         DP_WB_PRED:
            tmp_in = clamp_sum({icpt_ff[WORD_W-1], icpt_ff} + {tmp_ff[WORD_W-1], tmp_ff});
         DP_WB_IDX: begin
            if (tmp_ff[WORD_W-1]) begin
               idx_in = '0;
            end else if (round_hi >= (WORD_W-31)'(count_ff)) begin
               idx_in = IDX_W'(count_ff - CNT_W'(1));
            end else begin
               idx_in = IDX_W'(round_hi);
            end
         end
         DP_RD_CUR: rd_en = 1'b1;
         DP_STEP_DN: begin
            idx_in  = idx_ff - IDX_W'(1);
            rd_addr = idx_ff - IDX_W'(1);
            rd_en   = 1'b1;
         end
         DP_SET_CUR: cur_in = rd_ff;
         DP_RD_NEXT: begin
            rd_addr = idx_ff + IDX_W'(1);
            rd_en   = 1'b1;
         end
         DP_STEP_UP: begin
            idx_in = idx_ff + IDX_W'(1);
            cur_in = rd_ff;
         end
         default: ;
      endcase

      if (cmd.rsp_load) begin
         rsp_slot_in  = cmd.rsp_use_idx ? SLOT_W'(idx_ff) : '0;
         rsp_empty_in = cmd.rsp_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_WB_APPEND) begin
         mem[count_ff[IDX_W-1:0]] <= key_ff;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sx_ff    <= '0;
         sxx_ff   <= '0;
         sy_ff    <= '0;
         sxy_ff   <= '0;
         slope_ff <= '0;
         icpt_ff  <= '0;
      end else begin
         count_ff <= count_in;
         sx_ff    <= sx_in;
         sxx_ff   <= sxx_in;
         sy_ff    <= sy_in;
         sxy_ff   <= sxy_in;
         slope_ff <= slope_in;
         icpt_ff  <= icpt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      left_ff      <= left_in;
      mx_ff        <= mx_in;
      myq_ff       <= myq_in;
      mxy_ff       <= mxy_in;
      mxx_ff       <= mxx_in;
      var_ff       <= var_in;
      cov_ff       <= cov_in;
      tmp_ff       <= tmp_in;
      covneg_ff    <= covneg_in;
      degen_ff     <= degen_in;
      idx_ff       <= idx_in;
      cur_ff       <= cur_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   always_comb begin
      status.cmd         = cmd_ff;
      status.left        = left_ff;
      status.mul_done    = mul_done;
      status.div_done    = div_done;
      status.table_empty = (count_ff == '0);
      status.table_full  = (count_ff == CNT_W'(TABLE_DEPTH));
      status.degen       = degen_ff;
      status.rd_lt_key   = (rd_ff < key_ff);
      status.rd_eq_key   = (rd_ff == key_ff);
      status.cur_lt_key  = (cur_ff < key_ff);
      status.cur_eq_key  = (cur_ff == key_ff);
      status.idx_zero    = (idx_ff == '0);
      status.idx_last    = ((CNT_W'(idx_ff) + CNT_W'(1)) >= count_ff);
   end

   assign rsp_slot       = rsp_slot_ff;
   assign rsp_empty_flag = rsp_empty_ff;

endmodule
`default_nettype wire

// File: hw/rtl/lil_ctrl.sv
// Controller state machine that sequences append, build and lookup transactions.
`timescale 1ns / 1ps
`default_nettype none
module lil_ctrl
   import lil_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic           flag_ff, flag_in, use_ff, use_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           dn_go, up_go;

   always_comb begin
      state_in        = state_ff;
      flag_in         = flag_ff;
      use_in          = use_ff;
      cmd.req_take    = 1'b0;
      cmd.op          = DP_NOP;
      cmd.mul_start   = 1'b0;
      cmd.mul_a       = MA_KEY;
      cmd.mul_b       = MB_KEY;
      cmd.div_start   = 1'b0;
      cmd.div_num     = DN_SX;
      cmd.rsp_load    = 1'b0;
      cmd.rsp_flag    = flag_ff;
      cmd.rsp_use_idx = use_ff;
      req_stall       = (state_ff != ST_IDLE);
      // Left mode steps down over equal and larger entries; right mode only over larger ones.
      dn_go = !status.idx_zero &&
              (status.left ? !status.rd_lt_key : !(status.rd_lt_key || status.rd_eq_key));
      up_go = !status.idx_last &&
              (status.left ? status.cur_lt_key : (status.cur_lt_key || status.cur_eq_key));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_take = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.cmd)
               CMD_CLEAR: begin
                  cmd.op   = DP_CLEAR;
                  state_in = ST_IDLE;
               end
               CMD_APPEND: state_in = status.table_full ? ST_IDLE : ST_APP_SQ_GO;
               CMD_BUILD: begin
                  if (status.table_empty) begin
                     cmd.op   = DP_ZERO_FIT;
                     flag_in  = 1'b1;
                     use_in   = 1'b0;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_BLD_MX_GO;
                  end
               end
               CMD_LOOKUP: begin
                  if (status.table_empty) begin
                     flag_in  = 1'b1;
                     use_in   = 1'b0;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_LK_PRED_GO;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_APP_SQ_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_KEY;
            cmd.mul_b     = MB_KEY;
            state_in      = ST_APP_SQ_WAIT;
         end
         ST_APP_SQ_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = DP_WB_SQ;
               state_in = ST_APP_XY_GO;
            end
         end
         ST_APP_XY_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_CNT;
            cmd.mul_b     = MB_KEY;
            state_in      = ST_APP_XY_WAIT;
         end
         ST_APP_XY_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = DP_WB_APPEND;
               state_in = ST_IDLE;
            end
         end
         ST_BLD_MX_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_num   = DN_SX;
            state_in      = ST_BLD_MX_WAIT;
         end
         ST_BLD_MX_WAIT: begin
            if (status.div_done) begin
               cmd.op   = DP_WB_MX;
               state_in = ST_BLD_MYQ_GO;
            end
         end
         ST_BLD_MYQ_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_num   = DN_SY;
            state_in      = ST_BLD_MYQ_WAIT;
         end
         ST_BLD_MYQ_WAIT: begin
            if (status.div_done) begin
               cmd.op   = DP_WB_MYQ;
               state_in = ST_BLD_MXY_GO;
            end
         end
         ST_BLD_MXY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_num   = DN_SXY;
            state_in      = ST_BLD_MXY_WAIT;
         end
         ST_BLD_MXY_WAIT: begin
            if (status.div_done) begin
               cmd.op   = DP_WB_MXY;
               state_in = ST_BLD_MXX_GO;
            end
         end
         ST_BLD_MXX_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_num   = DN_SXX;
            state_in      = ST_BLD_MXX_WAIT;
         end
         ST_BLD_MXX_WAIT: begin
            if (status.div_done) begin
               cmd.op   = DP_WB_MXX;
               state_in = ST_BLD_T2_GO;
            end
         end
         ST_BLD_T2_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_MX;
            cmd.mul_b     = MB_MX;
            state_in      = ST_BLD_T2_WAIT;
         end
         ST_BLD_T2_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = DP_WB_T2;
               state_in = ST_BLD_CHECK;
            end
         end
         ST_BLD_CHECK: begin
            if (status.degen) begin
               cmd.op   = DP_DEGEN;
               flag_in  = 1'b1;
               use_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_BLD_T_GO;
            end
         end
         ST_BLD_T_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_MX;
            cmd.mul_b     = MB_MYQ;
            state_in      = ST_BLD_T_WAIT;
         end
         ST_BLD_T_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = DP_WB_T;
               state_in = ST_BLD_SLOPE_GO;
            end
         end
         ST_BLD_SLOPE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_num   = DN_COV;
            state_in      = ST_BLD_SLOPE_WAIT;
         end
         ST_BLD_SLOPE_WAIT: begin
            if (status.div_done) begin
               cmd.op   = DP_WB_SLOPE;
               state_in = ST_BLD_ICPT_GO;
            end
         end
         ST_BLD_ICPT_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_SLOPE;
            cmd.mul_b     = MB_MX;
            state_in      = ST_BLD_ICPT_WAIT;
         end
         ST_BLD_ICPT_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = DP_WB_SATMUL;
               state_in = ST_BLD_ICPT;
            end
         end
         ST_BLD_ICPT: begin
            cmd.op   = DP_WB_ICPT;
            flag_in  = 1'b0;
            use_in   = 1'b0;
            state_in = ST_FINISH;
         end
         ST_LK_PRED_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_SLOPE;
            cmd.mul_b     = MB_KEY;
            state_in      = ST_LK_PRED_WAIT;
         end
         ST_LK_PRED_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = DP_WB_SATMUL;
               state_in = ST_LK_PRED;
            end
         end
         ST_LK_PRED: begin
            cmd.op   = DP_WB_PRED;
            state_in = ST_LK_IDX;
         end
         ST_LK_IDX: begin
            cmd.op   = DP_WB_IDX;
            state_in = ST_LK_RD;
         end
         ST_LK_RD: begin
            cmd.op   = DP_RD_CUR;
            state_in = ST_LK_DN;
         end
         ST_LK_DN: begin
            if (dn_go) begin
               cmd.op = DP_STEP_DN;
            end else begin
               cmd.op   = DP_SET_CUR;
               state_in = ST_LK_UPC;
            end
         end
         ST_LK_UPC: begin
            if (up_go) begin
               cmd.op   = DP_RD_NEXT;
               state_in = ST_LK_UP;
            end else begin
               flag_in  = 1'b0;
               use_in   = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_LK_UP: begin
            if (status.rd_lt_key || status.rd_eq_key) begin
               cmd.op   = DP_STEP_UP;
               state_in = ST_LK_UPC;
            end else begin
               flag_in  = 1'b0;
               use_in   = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
      use_ff  <= use_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: hw/rtl/learned_index_lookup_unit.sv
// Learned index lookup unit: position table with a fitted linear slot predictor.
//
// Request channel (req_*): cmd 0 clears the table and the fit, 1 appends
// req_position at the next free slot, 2 fits the least-squares line and 3 looks
// up req_position as a key. Build and lookup each return one transaction on the
// result channel (rsp_*); clear and append return nothing.
// One transaction is processed at a time. Append makes two passes through the
// four-step 32 by 32 multiplier. Build makes five passes through the
// one-bit-per-cycle 64-bit divider (four when the fit is degenerate). Lookup
// makes one multiplier pass, then walks the table down and then up from the
// predicted slot; a look-ahead read of the next entry can end the walk.
// Build or lookup on an empty table returns a flagged result without arithmetic.
// A finished result sits in the output register while the next request is
// accepted; while rsp_stall is high the result holds and the next result waits
// in its final state. Reset (synchronous, active high) empties the table and
// zeroes the sums and the fit; the table storage itself is not cleared, so the
// unit accepts requests in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module learned_index_lookup_unit
   import lil_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int POS_BITS    = 31
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [POS_BITS-1:0] req_position,
   input  wire logic                req_left_mode,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic                     rsp_empty_flag
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   lil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   lil_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .POS_BITS    (POS_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_left_mode  (req_left_mode),
      .cmd            (ctrl_cmd),
      .status         (dp_status),
      .rsp_slot       (rsp_slot),
      .rsp_empty_flag (rsp_empty_flag)
   );

   // A flagged result never carries a slot.
   a_flag_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_flag |-> rsp_slot == '0)
      else $error("flagged result with nonzero slot");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in progress");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(dp_status.mul_done && dp_status.div_done))
      else $error("multiplier and divider finished together");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("pending result overwritten");

endmodule
`default_nettype wire
